// ----- design/shb_pkg.sv -----
// Shared types and constants for the string hash to bucket block.
// No dependencies; imported by every module of the block.
package shb_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int SLOT_W = 21;
    localparam int BKT_W  = 20;
    localparam int CNT_W  = $clog2(HASH_W);

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 56;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(30);
    localparam logic [SLOT_W-1:0] SLOT_MAX   = SLOT_W'(1048576);

    // register word index, taken from paddr[2]
    localparam logic REG_SLOT_COUNT = 1'b0;

    localparam int MIX_SHL  = 10;
    localparam int MIX_SHR  = 6;
    localparam int FIN_SHL1 = 3;
    localparam int FIN_SHR  = 11;
    localparam int FIN_SHL2 = 15;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_hash_req;

endpackage

// ----- design/shb_mixer.sv -----
// Byte mixer and finalizer around one shared 32-bit adder.
// Depends on shb_pkg; hands finished hashes to shb_remdiv.
module shb_mixer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [shb_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_last,
    output shb_pkg::t_hash_req          o_req,
    input  logic                        i_req_ready
);
    import shb_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MIX  = 5'b00010,
        M_FIN1 = 5'b00100,
        M_FIN2 = 5'b01000,
        M_HAND = 5'b10000
    } t_mix_state;

    t_mix_state        r_state, n_state;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic              r_last, n_last;
    logic [HASH_W-1:0] add_b;
    logic [HASH_W-1:0] sum;

    always_comb begin
        unique case (r_state)
            M_IDLE:  add_b = HASH_W'(i_byte);
            M_MIX:   add_b = r_hash << MIX_SHL;
            M_FIN1:  add_b = r_hash << FIN_SHL1;
            M_FIN2:  add_b = r_hash << FIN_SHL2;
            default: add_b = '0;
        endcase
    end

    assign sum = r_hash + add_b;

    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        n_last  = r_last;
        unique case (r_state)
            M_IDLE: begin
                if (i_valid) begin
                    n_hash  = sum;
                    n_last  = i_last;
                    n_state = M_MIX;
                end
            end
            M_MIX: begin
                n_hash  = sum ^ (sum >> MIX_SHR);
                n_state = r_last ? M_FIN1 : M_IDLE;
            end
            M_FIN1: begin
                n_hash  = sum ^ (sum >> FIN_SHR);
                n_state = M_FIN2;
            end
            M_FIN2: begin
                n_hash  = sum;
                n_state = M_HAND;
            end
            M_HAND: begin
                if (i_req_ready) begin
                    n_hash  = '0;
                    n_state = M_IDLE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_hash  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_last  <= n_last;
        end
    end

    assign o_ready     = (r_state == M_IDLE);
    assign o_req.valid = (r_state == M_HAND);
    assign o_req.hash  = r_hash;

endmodule

// ----- design/shb_remdiv.sv -----
// Bit-serial restoring remainder: hash modulo slot count (0 read as 1, capped at SLOT_MAX),
// one bit per cycle, with the result beat held in an output register. Depends on shb_pkg.
module shb_remdiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  shb_pkg::t_hash_req          i_req,
    output logic                        o_req_ready,
    input  logic [shb_pkg::SLOT_W-1:0]  i_slot_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [shb_pkg::HASH_W-1:0]  o_hash,
    output logic [shb_pkg::BKT_W-1:0]   o_bucket
);
    import shb_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } t_div_state;

    t_div_state        r_state;
    logic [HASH_W-1:0] r_shift;
    logic [HASH_W-1:0] r_hash;
    logic [BKT_W-1:0]  r_rem;
    logic [SLOT_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;

    logic [SLOT_W-1:0] eff_slots;
    logic [SLOT_W-1:0] rem2;
    logic [SLOT_W-1:0] diff;
    logic              ge;

    always_comb begin
        if (i_slot_count == '0) begin
            eff_slots = SLOT_W'(1);
        end else if (i_slot_count > SLOT_MAX) begin
            eff_slots = SLOT_MAX;
        end else begin
            eff_slots = i_slot_count;
        end
    end

    assign rem2 = {r_rem, r_shift[HASH_W-1]};
    assign ge   = (rem2 >= r_div);
    assign diff = rem2 - r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= D_RUN;
                        r_cnt   <= '0;
                    end
                end
                D_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(HASH_W - 1)) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    if (i_ready) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_req.valid) begin
            r_shift <= i_req.hash;
            r_hash  <= i_req.hash;
            r_rem   <= '0;
            r_div   <= eff_slots;
        end else if (r_state == D_RUN) begin
            r_shift <= r_shift << 1;
            r_rem   <= ge ? diff[BKT_W-1:0] : rem2[BKT_W-1:0];
        end
    end

    assign o_req_ready = (r_state == D_IDLE);
    assign o_valid     = (r_state == D_DONE);
    assign o_hash      = r_hash;
    assign o_bucket    = r_rem;

endmodule

// ----- design/string_hash_to_bucket.sv -----
// Top level of the string hash to bucket block: APB register, mixer, remainder unit.
// Depends on shb_pkg, shb_mixer and shb_remdiv.
//
// Bytes of a word arrive on the s_ stream, the last one flagged by s_tlast. The
// mixer adds each byte and then mixes it, running every add through one shared 32-bit
// adder; after the last byte it passes through the finalization states M_FIN1 and M_FIN2
// and holds the hash in M_HAND until the remainder unit takes it. The bucket index comes
// from a bit-serial remainder unit that loads the hash, works through its 32 bits and holds
// the result beat until it is taken; it runs while the bytes of the next word are mixed,
// though the mixer holds the next hash until the unit is idle. One result beat per word leaves on the m_ stream.
module string_hash_to_bucket (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [shb_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] text_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [shb_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [31:0] hash_value, [51:32] bucket_index
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [shb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [shb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [shb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import shb_pkg::*;

    logic [SLOT_W-1:0] r_slot_count;
    t_hash_req         req;
    logic              req_ready;
    logic [HASH_W-1:0] res_hash;
    logic [BKT_W-1:0]  res_bucket;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SLOT_COUNT) begin
            r_slot_count <= pwdata[SLOT_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SLOT_COUNT: prdata = APB_DATA_W'(r_slot_count);
            default:        prdata = '0;
        endcase
    end

    shb_mixer u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_byte      (s_tdata[BYTE_W-1:0]),
        .i_last      (s_tlast),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    shb_remdiv u_remdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_req_ready  (req_ready),
        .i_slot_count (r_slot_count),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_hash       (res_hash),
        .o_bucket     (res_bucket)
    );

    assign m_tdata = {(TDATA_OUT_W - HASH_W - BKT_W)'(0), res_bucket, res_hash};

endmodule
